// ===== rtl/edf_dbc_pkg.sv =====
// shared types and constants for the edf demand bound check unit
`timescale 1ns / 1ps

package edf_dbc_pkg;

  localparam int FIELD_W        = 32;
  localparam int DEMAND_W       = 48;
  localparam int TIME_WIDTH_DEF = 32;

  localparam logic [DEMAND_W-1:0] DEMAND_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_MULT,
    ST_ACCUM
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic mult;
    logic accum;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;
    logic div_done;
    logic last;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/edf_demand_bound_check_unit.sv =====
// edf demand bound check: per-task demand at a horizon, summed over a task set
// sequence: each task transaction passes the idle, divide, multiply and accumulate states in turn;
//   the divide state runs the restoring divider that yields one quotient bit per cycle;
//   a task with a non-positive count or zero period skips the divider
// throughput: one task at a time; the next is taken when the previous one is summed,
//   and a closing task also waits while the previous set total is not yet taken
// reset: synchronous; clears the horizon, the running demand and the output valid
`timescale 1ns / 1ps

module edf_demand_bound_check_unit #(
  parameter int TIME_WIDTH = edf_dbc_pkg::TIME_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [edf_dbc_pkg::FIELD_W-1:0]  horizon,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [edf_dbc_pkg::FIELD_W-1:0]  period,
  input  logic [edf_dbc_pkg::FIELD_W-1:0]  deadline,
  input  logic [edf_dbc_pkg::FIELD_W-1:0]  wcet,
  input  logic                             last_task,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [edf_dbc_pkg::DEMAND_W-1:0] demand,
  output logic                             schedulable
);

  edf_dbc_pkg::cmd_t    cmd;
  edf_dbc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  edf_dbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  edf_dbc_datapath #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .horizon     (horizon),
    .period      (period),
    .deadline    (deadline),
    .wcet        (wcet),
    .last_task   (last_task),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .demand      (demand),
    .schedulable (schedulable)
  );

endmodule

// ===== rtl/edf_dbc_ctrl.sv =====
// controller state machine for the edf demand bound check unit
`timescale 1ns / 1ps

module edf_dbc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  edf_dbc_pkg::status_t status,
  output edf_dbc_pkg::cmd_t    cmd
);

  edf_dbc_pkg::state_t state;
  edf_dbc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= edf_dbc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      edf_dbc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = edf_dbc_pkg::ST_DIVIDE;
        end
      end
      edf_dbc_pkg::ST_DIVIDE: begin
        // negative count or zero period needs no division
        if (status.skip || status.div_done) begin
          state_next = edf_dbc_pkg::ST_MULT;
        end
      end
      edf_dbc_pkg::ST_MULT: begin
        state_next = edf_dbc_pkg::ST_ACCUM;
      end
      edf_dbc_pkg::ST_ACCUM: begin
        if (!(status.last && status.out_busy)) begin
          state_next = edf_dbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = edf_dbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state)
      edf_dbc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      edf_dbc_pkg::ST_DIVIDE: begin
        cmd.div_step = !status.skip;
      end
      edf_dbc_pkg::ST_MULT: begin
        cmd.mult = 1'b1;
      end
      edf_dbc_pkg::ST_ACCUM: begin
        // hold a closing transaction until the output register is free
        cmd.accum = !(status.last && status.out_busy);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/edf_dbc_datapath.sv =====
// datapath: horizon register, serial divider, multiplier, saturating accumulator
`timescale 1ns / 1ps

module edf_dbc_datapath #(
  parameter int TIME_WIDTH = edf_dbc_pkg::TIME_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [edf_dbc_pkg::FIELD_W-1:0]     horizon,
  input  logic [edf_dbc_pkg::FIELD_W-1:0]     period,
  input  logic [edf_dbc_pkg::FIELD_W-1:0]     deadline,
  input  logic [edf_dbc_pkg::FIELD_W-1:0]     wcet,
  input  logic                                last_task,
  input  edf_dbc_pkg::cmd_t                   cmd,
  output edf_dbc_pkg::status_t                status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [edf_dbc_pkg::DEMAND_W-1:0]    demand,
  output logic                                schedulable
);

  localparam int DW = (TIME_WIDTH < edf_dbc_pkg::FIELD_W) ? TIME_WIDTH : edf_dbc_pkg::FIELD_W;
  localparam int NW = DW + 1;
  localparam int CW = $clog2(NW + 1);
  localparam int PW = DW + NW;
  localparam int SW = (PW > edf_dbc_pkg::DEMAND_W) ? PW : edf_dbc_pkg::DEMAND_W;
  localparam int DMW = edf_dbc_pkg::DEMAND_W;

  logic [DW-1:0]  horizon_r;
  logic [DW-1:0]  period_r;
  logic [DW-1:0]  wcet_r;
  logic           last_r;
  logic           skip;
  logic [NW-1:0]  quot;
  logic [DW-1:0]  rem;
  logic [CW-1:0]  cnt;
  logic [PW-1:0]  prod;
  logic [DMW-1:0] running;

  logic [NW-1:0]  num_sum;
  logic [NW-1:0]  dl_ext;
  logic [NW-1:0]  trial;
  logic           trial_ge;
  logic [SW-1:0]  prod_ext;
  logic [DMW-1:0] contrib;
  logic [DMW:0]   sum;
  logic [DMW-1:0] sum_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      horizon_r <= '0;
    end else if (cfg_valid) begin
      horizon_r <= horizon[DW-1:0];
    end
  end

  // t + period - deadline, one bit wider than a time value
  assign num_sum = {1'b0, horizon_r} + {1'b0, period[DW-1:0]};
  assign dl_ext  = {1'b0, deadline[DW-1:0]};

  // restoring divider, one quotient bit per cycle
  assign trial    = {rem, quot[NW-1]};
  assign trial_ge = trial >= {1'b0, period_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      period_r <= period[DW-1:0];
      wcet_r   <= wcet[DW-1:0];
      last_r   <= last_task;
      skip     <= (period[DW-1:0] == '0) || (num_sum <= dl_ext);
      quot     <= num_sum - dl_ext;
      rem      <= '0;
      cnt      <= CW'(NW);
    end else if (cmd.div_step) begin
      rem  <= trial_ge ? DW'(trial - {1'b0, period_r}) : trial[DW-1:0];
      quot <= {quot[NW-2:0], trial_ge};
      cnt  <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod <= skip ? '0 : PW'(wcet_r) * PW'(quot);
    end
  end

  assign prod_ext = SW'(prod);
  assign contrib  = (prod_ext > SW'(edf_dbc_pkg::DEMAND_MAX)) ? edf_dbc_pkg::DEMAND_MAX
                                                               : prod_ext[DMW-1:0];
  assign sum      = {1'b0, running} + {1'b0, contrib};
  assign sum_sat  = sum[DMW] ? edf_dbc_pkg::DEMAND_MAX : sum[DMW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accum && last_r) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.accum) begin
        running <= last_r ? '0 : sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accum && last_r) begin
      demand      <= sum_sat;
      schedulable <= sum_sat < DMW'(horizon_r);
    end
  end

  assign status.skip     = skip;
  assign status.div_done = (cnt == CW'(1));
  assign status.last     = last_r;
  assign status.out_busy = out_valid && !out_ready;

endmodule
